### hw/rtl/set_assoc_cache_tag_lookup_macros.svh
// Assertion macros shared by the tag lookup RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_MACROS_SVH

// checked only out of reset
`define SACL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define SACL_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/sacl_pkg.sv
// Package for the cache tag lookup: sizes, codes, register map and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sacl_pkg;

  localparam int ADDR_W  = 32;
  localparam int SETS    = 4096;
  localparam int SET_W   = $clog2(SETS);
  localparam int WAYS    = 4;
  localparam int WAY_W   = 2;
  localparam int AGE_W   = 2;
  localparam int TAG_W   = ADDR_W;
  localparam int CNT_W   = 32;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FETCH = 2'd2,
    ACT_OTHER = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_OFFSET_BITS = 2'd0,
    REG_INDEX_BITS  = 2'd1,
    REG_FOUR_WAY    = 2'd2,
    REG_SPLIT_MODE  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [3:0] offset_bits;
    logic [3:0] index_bits;
    logic       four_way;
    logic       split_mode;
  } cfg_t;

  typedef struct packed {
    logic clear;   // write one cleared row
    logic accept;  // capture transaction, read its set
    logic commit;  // write back row, load result
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0] tag;
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0][AGE_W-1:0] age;
  } row_t;

endpackage

`default_nettype wire

### hw/rtl/sacl_in_if.sv
// Input channel interface: valid/ready handshake with action and address.
// Depends on sacl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sacl_in_if;
  import sacl_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output action, output address, input ready);
  modport sink   (input valid, input action, input address, output ready);
endinterface

`default_nettype wire

### hw/rtl/sacl_out_if.sv
// Result channel interface: valid/ready handshake with lookup result and counters.
// Depends on sacl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sacl_out_if;
  import sacl_pkg::*;

  logic             valid;
  logic             ready;
  logic             looked_up;
  logic             hit;
  logic [WAY_W-1:0] way_used;
  logic [CNT_W-1:0] access_count;
  logic [CNT_W-1:0] hit_count;
  logic [CNT_W-1:0] miss_count;

  modport source (output valid, output looked_up, output hit, output way_used,
                  output access_count, output hit_count, output miss_count,
                  input ready);
  modport sink   (input valid, input looked_up, input hit, input way_used,
                  input access_count, input hit_count, input miss_count,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/sacl_regs.sv
// APB-style configuration registers of the tag lookup.
// Depends on sacl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sacl_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sacl_pkg::PADDR_W-1:0] paddr,
  input  wire logic [sacl_pkg::PDATA_W-1:0] pwdata,
  output logic      [sacl_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output sacl_pkg::cfg_t                   cfg
);
  import sacl_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t sel;
  logic     wr_en;

  assign sel    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (sel)
        REG_OFFSET_BITS: cfg_nxt.offset_bits = pwdata[3:0];
        REG_INDEX_BITS:  cfg_nxt.index_bits  = pwdata[3:0];
        REG_FOUR_WAY:    cfg_nxt.four_way    = pwdata[0];
        REG_SPLIT_MODE:  cfg_nxt.split_mode  = pwdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_OFFSET_BITS: prdata = PDATA_W'(cfg_r.offset_bits);
      REG_INDEX_BITS:  prdata = PDATA_W'(cfg_r.index_bits);
      REG_FOUR_WAY:    prdata = PDATA_W'(cfg_r.four_way);
      REG_SPLIT_MODE:  prdata = PDATA_W'(cfg_r.split_mode);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_bits <= 4'd5;
      cfg_r.index_bits  <= 4'd8;
      cfg_r.four_way    <= 1'b0;
      cfg_r.split_mode  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sacl_ctrl.sv
// Controller of the tag lookup: clear sweep, accept and commit sequencing.
// Depends on sacl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_cache_tag_lookup_macros.svh"

module sacl_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire sacl_pkg::sts_t sts,
  output sacl_pkg::cmd_t      cmd
);
  import sacl_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (sts.clear_done) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_UPDATE;
      ST_UPDATE: if (!sts.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clear = !sts.clear_done;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_UPDATE: cmd.commit = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SACL_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> state_r == ST_CLEAR, "reset did not start clear")
  `SACL_ASSERT(a_accept_then_update, cmd.accept |=> state_r == ST_UPDATE, "accept lost")
  `SACL_ASSERT(a_no_accept_in_clear, !sts.clear_done |-> !(in_valid && in_ready), "accept in clear")

endmodule

`default_nettype wire

### hw/rtl/sacl_dp.sv
// Datapath of the tag lookup: set RAM, compare, LRU victim and update, counters,
// result register. Depends on sacl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_cache_tag_lookup_macros.svh"

module sacl_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sacl_pkg::cfg_t              cfg,
  input  wire sacl_pkg::cmd_t              cmd,
  output sacl_pkg::sts_t                   sts,
  input  wire logic [1:0]                  in_action,
  input  wire logic [sacl_pkg::ADDR_W-1:0] in_address,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_looked_up,
  output logic                             out_hit,
  output logic      [sacl_pkg::WAY_W-1:0]  out_way_used,
  output logic      [sacl_pkg::CNT_W-1:0]  out_access_count,
  output logic      [sacl_pkg::CNT_W-1:0]  out_hit_count,
  output logic      [sacl_pkg::CNT_W-1:0]  out_miss_count
);
  import sacl_pkg::*;

  row_t mem [SETS];

  logic [SET_W:0]   clr_ptr_r, clr_ptr_nxt;
  row_t             rd_row_r;
  logic [TAG_W-1:0] line_r;
  logic [SET_W-1:0] set_r;
  logic             skip_r;
  logic             out_valid_r, out_valid_nxt;
  logic             looked_r, hit_r;
  logic [WAY_W-1:0] way_r;
  logic [CNT_W-1:0] acc_r, acc_nxt, hits_r, hits_nxt, miss_r, miss_nxt;

  logic [TAG_W-1:0] line_c;
  logic [SET_W-1:0] idx_mask_c, set_c;
  logic [WAYS-1:0]  match_c;
  logic             hit_c, full_c, was_valid_c;
  logic [WAY_W-1:0] hit_way_c, inv_way_c, old_way_c, victim_c, used_c;
  logic [AGE_W-1:0] best_age_c, used_age_c;
  row_t             new_row_c, wr_row_c;
  logic             we_c;
  logic [SET_W-1:0] wr_set_c;

  // address split
  always_comb begin
    line_c     = in_address >> cfg.offset_bits;
    idx_mask_c = (cfg.index_bits >= 4'(SET_W)) ? {SET_W{1'b1}}
                                               : ~({SET_W{1'b1}} << cfg.index_bits);
    set_c      = line_c[SET_W-1:0] & idx_mask_c;
  end

  // compare, victim select, LRU update
  always_comb begin
    match_c = '0;
    for (int w = 0; w < WAYS; w++) begin
      match_c[w] = rd_row_r.valid[w] && (rd_row_r.tag[w] == line_r) &&
                   (cfg.four_way || (w == 0));
    end
    hit_c     = |match_c;
    full_c    = &rd_row_r.valid;
    hit_way_c = '0;
    inv_way_c = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match_c[w]) hit_way_c = WAY_W'(w);
      if (!rd_row_r.valid[w]) inv_way_c = WAY_W'(w);
    end
    old_way_c  = '0;
    best_age_c = rd_row_r.age[0];
    for (int w = 1; w < WAYS; w++) begin
      if (rd_row_r.age[w] > best_age_c) begin
        best_age_c = rd_row_r.age[w];
        old_way_c  = WAY_W'(w);
      end
    end
    if (!cfg.four_way) victim_c = '0;
    else if (!full_c)  victim_c = inv_way_c;
    else               victim_c = old_way_c;
    used_c      = hit_c ? hit_way_c : victim_c;
    was_valid_c = hit_c || full_c;
    used_age_c  = rd_row_r.age[used_c];

    new_row_c = rd_row_r;
    if (!hit_c) begin
      new_row_c.tag[victim_c]   = line_r;
      new_row_c.valid[victim_c] = 1'b1;
    end
    if (cfg.four_way) begin
      for (int w = 0; w < WAYS; w++) begin
        if ((WAY_W'(w) != used_c) && rd_row_r.valid[w] &&
            (!was_valid_c || (rd_row_r.age[w] < used_age_c)) &&
            (rd_row_r.age[w] < AGE_MAX)) begin
          new_row_c.age[w] = rd_row_r.age[w] + AGE_W'(1);
        end
      end
      new_row_c.age[used_c] = '0;
    end
  end

  // RAM write port
  always_comb begin
    we_c     = cmd.clear || (cmd.commit && !skip_r);
    wr_set_c = cmd.clear ? clr_ptr_r[SET_W-1:0] : set_r;
    wr_row_c = cmd.clear ? row_t'('0) : new_row_c;
  end

  always_ff @(posedge clk) begin
    if (we_c) begin
      mem[wr_set_c] <= wr_row_c;
    end
    if (cmd.accept) begin
      rd_row_r <= mem[set_c];
    end
  end

  // counters and result
  always_comb begin
    clr_ptr_nxt   = cmd.clear ? clr_ptr_r + (SET_W+1)'(1) : clr_ptr_r;
    acc_nxt       = acc_r;
    hits_nxt      = hits_r;
    miss_nxt      = miss_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      if (!skip_r) begin
        acc_nxt = (acc_r == '1) ? acc_r : acc_r + CNT_W'(1);
        if (hit_c) hits_nxt = (hits_r == '1) ? hits_r : hits_r + CNT_W'(1);
        else       miss_nxt = (miss_r == '1) ? miss_r : miss_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r   <= '0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      hits_r      <= '0;
      miss_r      <= '0;
    end else begin
      clr_ptr_r   <= clr_ptr_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      hits_r      <= hits_nxt;
      miss_r      <= miss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      line_r <= line_c;
      set_r  <= set_c;
      skip_r <= cfg.split_mode && (action_t'(in_action) == ACT_FETCH);
    end
    if (cmd.commit) begin
      looked_r <= !skip_r;
      hit_r    <= !skip_r && hit_c;
      way_r    <= skip_r ? '0 : used_c;
    end
  end

  assign sts.clear_done   = clr_ptr_r[SET_W];
  assign sts.out_busy     = out_valid_r && !out_ready;
  assign out_valid        = out_valid_r;
  assign out_looked_up    = looked_r;
  assign out_hit          = hit_r;
  assign out_way_used     = way_r;
  assign out_access_count = acc_r;
  assign out_hit_count    = hits_r;
  assign out_miss_count   = miss_r;

  `SACL_ASSERT(a_commit_slot_free, cmd.commit |-> !(out_valid_r && !out_ready), "result overwritten")
  `SACL_ASSERT(a_hit_looked_up, (out_valid_r && hit_r) |-> looked_r, "hit on skipped transaction")
  `SACL_ASSERT(a_fill_invalid_first, (cmd.commit && !skip_r && !hit_c && cfg.four_way && !full_c) |-> !rd_row_r.valid[victim_c], "valid way evicted before invalid way")

endmodule

`default_nettype wire

### hw/rtl/set_assoc_cache_tag_lookup.sv
// Top level of the set-associative cache tag lookup.
// Depends on sacl_pkg, sacl_in_if, sacl_out_if, sacl_regs, sacl_ctrl, sacl_dp.
//
//   port group   direction  contents
//   in_chan      sink       action, address
//   out_chan     source     looked_up, hit, way_used, access/hit/miss counts
//   APB          slave      offset_bits, index_bits, four_way, split_mode
//
// Each transaction is an accept (set RAM read), then a compare and write-back.
// After reset a clear sweep writes all 4096 sets, one set per cycle; in_chan.ready stays low.
// A full result register holds the commit; no new transaction is accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_tag_lookup (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  sacl_in_if.sink                          in_chan,
  sacl_out_if.source                       out_chan,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sacl_pkg::PADDR_W-1:0] paddr,
  input  wire logic [sacl_pkg::PDATA_W-1:0] pwdata,
  output logic      [sacl_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);
  import sacl_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  sacl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sacl_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_chan.action),
    .in_address       (in_chan.address),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_looked_up    (out_chan.looked_up),
    .out_hit          (out_chan.hit),
    .out_way_used     (out_chan.way_used),
    .out_access_count (out_chan.access_count),
    .out_hit_count    (out_chan.hit_count),
    .out_miss_count   (out_chan.miss_count)
  );

endmodule

`default_nettype wire

### bench/set_assoc_cache_tag_lookup_test.sv
// Testbench for set_assoc_cache_tag_lookup: random trace accesses checked against a
// tag/LRU directory model kept in the bench, across several cache geometries.
// Depends on sacl_pkg, sacl_in_if, sacl_out_if and the RTL top level.
`timescale 1ns / 1ps

module set_assoc_cache_tag_lookup_test;
  import sacl_pkg::*;

  typedef struct packed {
    logic             looked_up;
    logic             hit;
    logic [WAY_W-1:0] way_used;
    logic [CNT_W-1:0] access_count;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
  } lookup_t;

  typedef struct {
    action_t           action;
    logic [ADDR_W-1:0] address;
  } access_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  wire  [PDATA_W-1:0] prdata;
  wire                pready;

  sacl_in_if  in_ch ();
  sacl_out_if out_ch ();

  set_assoc_cache_tag_lookup dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  // directory mirror
  logic [3:0]        cfg_offset = 4'd5;
  logic [3:0]        cfg_index  = 4'd8;
  logic              cfg_four   = 1'b0;
  logic              cfg_split  = 1'b0;
  logic [ADDR_W-1:0] line_tag  [SETS][WAYS];
  bit                way_valid [SETS][WAYS];
  bit   [AGE_W-1:0]  way_age   [SETS][WAYS];
  logic [CNT_W-1:0]  accesses_total = '0;
  logic [CNT_W-1:0]  hits_total     = '0;
  logic [CNT_W-1:0]  misses_total   = '0;

  access_t pending_accesses [$];
  lookup_t expected_lookups [$];
  int      items_queued  = 0;
  int      results_seen  = 0;
  int      mismatches    = 0;
  int      send_gap_pct  = 0;
  int      recv_gap_pct  = 0;
  bit      hold_go       = 1'b0;
  logic    stall_out     = 1'b0;

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic lookup_t predict_lookup(action_t act, logic [ADDR_W-1:0] addr);
    lookup_t           r;
    logic [ADDR_W-1:0] line_no;
    logic [AGE_W-1:0]  old_age;
    int                s, nways, u, w;
    bit                found, filled_invalid;
    r = '0;
    if (!(cfg_split && act == ACT_FETCH)) begin
      line_no = addr >> cfg_offset;
      s = int'((line_no & ((32'd1 << cfg_index) - 32'd1)) % SETS);
      nways = cfg_four ? WAYS : 1;
      found = 1'b0;
      filled_invalid = 1'b0;
      u = 0;
      accesses_total = bump(accesses_total);
      for (w = 0; w < nways && !found; w++) begin
        if (way_valid[s][w] && line_tag[s][w] == line_no) begin
          found = 1'b1;
          u = w;
        end
      end
      if (found) begin
        hits_total = bump(hits_total);
      end else begin
        misses_total = bump(misses_total);
        if (cfg_four) begin
          u = -1;
          for (w = 0; w < WAYS; w++)
            if (!way_valid[s][w] && u < 0) u = w;
          if (u >= 0) begin
            filled_invalid = 1'b1;
          end else begin
            u = 0;
            for (w = 1; w < WAYS; w++)
              if (way_age[s][w] > way_age[s][u]) u = w;
          end
        end
        line_tag[s][u] = line_no;
        way_valid[s][u] = 1'b1;
      end
      if (cfg_four) begin
        old_age = way_age[s][u];
        for (w = 0; w < WAYS; w++) begin
          if (w != u && way_valid[s][w] && (filled_invalid || way_age[s][w] < old_age)
              && way_age[s][w] != AGE_MAX)
            way_age[s][w] = way_age[s][w] + 1'b1;
        end
        way_age[s][u] = '0;
      end
      r.looked_up = 1'b1;
      r.hit = found;
      r.way_used = WAY_W'(u);
    end
    r.access_count = accesses_total;
    r.hit_count = hits_total;
    r.miss_count = misses_total;
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_lookups.push_back(predict_lookup(action_t'(in_ch.action), in_ch.address));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_accesses.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_ch.valid   <= 1'b1;
          in_ch.action  <= pending_accesses[0].action;
          in_ch.address <= pending_accesses[0].address;
          void'(pending_accesses.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : result_check
    lookup_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.looked_up, out_ch.hit, out_ch.way_used,
               out_ch.access_count, out_ch.hit_count, out_ch.miss_count};
        results_seen++;
        if (expected_lookups.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected lookup transaction, nothing pending", $time);
        end else begin
          want = expected_lookups.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: lookup mismatch", $time);
              $display("  exp looked_up=%0b hit=%0b way=%0d acc=%0d hits=%0d misses=%0d",
                       want.looked_up, want.hit, want.way_used, want.access_count,
                       want.hit_count, want.miss_count);
              $display("  got looked_up=%0b hit=%0b way=%0d acc=%0d hits=%0d misses=%0d",
                       got.looked_up, got.hit, got.way_used, got.access_count,
                       got.hit_count, got.miss_count);
            end
          end
        end
      end
      out_ch.ready <= !stall_out && ($urandom_range(99) >= recv_gap_pct);
    end
  end

  initial begin : long_stall
    wait (hold_go);
    @(posedge clk);
    stall_out <= 1'b1;
    repeat (300) @(posedge clk);
    stall_out <= 1'b0;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic queue_access(action_t act, logic [ADDR_W-1:0] addr);
    access_t a;
    a.action = act;
    a.address = addr;
    pending_accesses.push_back(a);
    items_queued++;
  endtask

  task automatic wait_all_results;
    wait (results_seen == items_queued);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [PDATA_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(int offs, int idx, bit four, bit split);
    write_reg(REG_OFFSET_BITS, PDATA_W'(offs));
    cfg_offset = 4'(offs);
    write_reg(REG_INDEX_BITS, PDATA_W'(idx));
    cfg_index = 4'(idx);
    write_reg(REG_FOUR_WAY, PDATA_W'(four));
    cfg_four = four;
    write_reg(REG_SPLIT_MODE, PDATA_W'(split));
    cfg_split = split;
  endtask

  // mostly reuse of a small working set so sets fill, hit and evict
  task automatic queue_random(int n);
    logic [ADDR_W-1:0] tags [6];
    logic [ADDR_W-1:0] sets [4];
    logic [ADDR_W-1:0] line_no, addr, off_mask;
    action_t           act;
    int                k, pick;
    off_mask = (32'd1 << cfg_offset) - 32'd1;
    for (k = 0; k < 6; k++) tags[k] = $urandom;
    for (k = 0; k < 4; k++) sets[k] = $urandom & ((32'd1 << cfg_index) - 32'd1);
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      act = (pick < 35) ? ACT_READ : (pick < 65) ? ACT_WRITE :
            (pick < 90) ? ACT_FETCH : ACT_OTHER;
      if ($urandom_range(99) < 15) begin
        addr = $urandom;
      end else begin
        line_no = (tags[$urandom_range(5)] << cfg_index) | sets[$urandom_range(3)];
        addr = (line_no << cfg_offset) | ($urandom & off_mask);
      end
      queue_access(act, addr);
    end
  endtask

  initial begin : stimulus
    int ph_off   [8] = '{12, 2, 2, 3, 12, 6, 4, 5};
    int ph_idx   [8] = '{12, 0, 12, 4, 0, 3, 1, 8};
    bit ph_four  [8] = '{1, 1, 0, 1, 0, 1, 1, 0};
    bit ph_split [8] = '{0, 1, 0, 0, 1, 1, 0, 0};
    int p;
    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_READ;
    in_ch.address = '0;
    out_ch.ready  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 18;
    recv_gap_pct = 75;
    // reset geometry, direct-mapped: fill, hit, conflict eviction, address extremes
    queue_access(ACT_READ,  32'h0000_0000);
    queue_access(ACT_WRITE, 32'h0000_0000);
    queue_access(ACT_FETCH, 32'hFFFF_FFFF);
    queue_access(ACT_OTHER, 32'hFFFF_FFE0);
    queue_access(ACT_READ,  32'h0000_2000);
    queue_access(ACT_READ,  32'h0000_0000);
    wait_all_results;

    // four-way, split: contents kept across the switch, invalid fill, LRU victim
    set_config(4, 2, 1'b1, 1'b1);
    queue_access(ACT_READ,  32'h0000_0000);
    queue_access(ACT_READ,  32'h0000_0040);
    queue_access(ACT_WRITE, 32'h0000_0080);
    queue_access(ACT_READ,  32'h0000_00C0);
    queue_access(ACT_FETCH, 32'h0000_0100);
    queue_access(ACT_READ,  32'h0000_0040);
    queue_access(ACT_READ,  32'h0000_0100);
    queue_access(ACT_OTHER, 32'h0000_0100);
    queue_access(ACT_FETCH, 32'hFFFF_FFFF);
    queue_access(ACT_WRITE, 32'hFFFF_FFFF);
    queue_access(ACT_READ,  32'h0000_00C0);
    queue_access(ACT_READ,  32'h0000_0140);
    wait_all_results;

    for (p = 0; p < 8; p++) begin
      send_gap_pct = (p < 3) ? 18 : (p < 6) ? 75 : 0;
      recv_gap_pct = (p < 3) ? 75 : (p < 6) ? 18 : 0;
      set_config(ph_off[p], ph_idx[p], ph_four[p], ph_split[p]);
      queue_random(112);
      if (p == 0) hold_go = 1'b1;
      wait_all_results;
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_lookups.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/sacl_pkg.sv
hw/rtl/sacl_in_if.sv
hw/rtl/sacl_out_if.sv
hw/rtl/sacl_regs.sv
hw/rtl/sacl_ctrl.sv
hw/rtl/sacl_dp.sv
hw/rtl/set_assoc_cache_tag_lookup.sv
bench/set_assoc_cache_tag_lookup_test.sv
